### hw/rtl/cose_pkg.sv
package cose_pkg;

  localparam logic [10:0] MAX_COLUMN_HEIGHT = 11'd1024;

  localparam logic [10:0] COLUMN_HEIGHT_RST = 11'd64;
  localparam logic [10:0] MIN_CLEARANCE_RST = 11'd2;

  localparam logic [0:0] CFG_COLUMN_HEIGHT = 1'b0;
  localparam logic [0:0] CFG_MIN_CLEARANCE = 1'b1;

  localparam logic [1:0] VOX_EMPTY = 2'd0;
  localparam logic [1:0] VOX_WALK  = 2'd1;

  localparam logic [10:0] LEN_SAT = 11'h7FF;

  localparam int unsigned OUT_DEPTH = 4;

  typedef struct packed {
    logic        span_valid;
    logic [9:0]  span_bottom;
    logic [10:0] span_height;
    logic        column_end;
  } res_t;

endpackage

### hw/rtl/column_open_span_extract.sv
// results of a voxel are written to the four-entry result queue when the
//   voxel is accepted and are offered from its single read port in order
// throughput: one voxel per cycle while out_tready holds and each voxel yields
//   at most one result; a voxel that yields two results sends them out one at a time
// reset: rst_n synchronous, active low; column state and queue cleared,
//   column_height back to 64 and min_clearance back to 2
module column_open_span_extract (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [1:0] voxel_state
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [9:0] span_bottom, [20:10] span_height
  output logic        out_tuser,  // [0] span_valid
  output logic        out_tlast,  // column_end
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_wdata
);

  logic [10:0] column_height_r;
  logic [10:0] min_clearance_r;

  logic [9:0]  height_index_r, height_index_nxt;
  logic        span_open_r, span_open_nxt;
  logic        gap_seen_r, gap_seen_nxt;
  logic [9:0]  open_bottom_r, open_bottom_nxt;
  logic [10:0] open_length_r, open_length_nxt;

  cose_pkg::res_t mem_r [cose_pkg::OUT_DEPTH];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r;

  logic        in_acc, out_acc;
  logic [1:0]  voxel;
  logic [10:0] ceiling;
  logic        below, keep, do_close, top, top_res;
  logic [10:0] top_h;
  logic [1:0]  n_res;
  cose_pkg::res_t close_rec, top_rec, first_rec;

  assign in_tready  = (cnt_r <= 3'd2);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != 3'd0);
  assign out_acc    = out_tvalid && out_tready;
  assign voxel      = in_tdata[1:0];

  always_comb begin
    if (column_height_r == 11'd0) begin
      ceiling = 11'd1;
    end else if (column_height_r > cose_pkg::MAX_COLUMN_HEIGHT) begin
      ceiling = cose_pkg::MAX_COLUMN_HEIGHT;
    end else begin
      ceiling = column_height_r;
    end
  end

  assign below = (({2'b00, open_bottom_r} + {1'b0, open_length_r}) < {1'b0, ceiling});
  assign keep  = span_open_r && !((open_length_r < min_clearance_r) && below);

  always_comb begin
    do_close        = 1'b0;
    span_open_nxt   = span_open_r;
    gap_seen_nxt    = gap_seen_r;
    open_bottom_nxt = open_bottom_r;
    open_length_nxt = open_length_r;
    case (voxel)
      cose_pkg::VOX_EMPTY: begin
        gap_seen_nxt = 1'b1;
        if (span_open_r && (open_length_r != cose_pkg::LEN_SAT)) begin
          open_length_nxt = open_length_r + 11'd1;
        end
      end
      cose_pkg::VOX_WALK: begin
        if (gap_seen_r || !span_open_r) begin
          do_close        = keep;
          span_open_nxt   = 1'b1;
          open_bottom_nxt = height_index_r;
          open_length_nxt = 11'd1;
          gap_seen_nxt    = 1'b0;
        end else if (open_length_r != cose_pkg::LEN_SAT) begin
          open_length_nxt = open_length_r + 11'd1;
        end
      end
      default: begin
        do_close      = keep;
        span_open_nxt = 1'b0;
      end
    endcase
  end

  assign top     = (({1'b0, height_index_r} + 11'd1) >= ceiling);
  assign top_res = top && (span_open_nxt || !do_close);
  assign top_h   = ({1'b0, open_bottom_nxt} < ceiling) ?
                   (ceiling - {1'b0, open_bottom_nxt}) : 11'd0;

  always_comb begin
    close_rec.span_valid  = 1'b1;
    close_rec.span_bottom = open_bottom_r;
    close_rec.span_height = open_length_r;
    close_rec.column_end  = top && !top_res;
    top_rec.span_valid    = span_open_nxt;
    top_rec.span_bottom   = span_open_nxt ? open_bottom_nxt : 10'd0;
    top_rec.span_height   = span_open_nxt ? top_h : 11'd0;
    top_rec.column_end    = 1'b1;
    first_rec             = do_close ? close_rec : top_rec;
    n_res                 = {1'b0, do_close} + {1'b0, top_res};
  end

  always_comb begin
    if (top) begin
      height_index_nxt = 10'd0;
    end else begin
      height_index_nxt = height_index_r + 10'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_height_r <= cose_pkg::COLUMN_HEIGHT_RST;
      min_clearance_r <= cose_pkg::MIN_CLEARANCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cose_pkg::CFG_COLUMN_HEIGHT: column_height_r <= cfg_wdata;
        cose_pkg::CFG_MIN_CLEARANCE: min_clearance_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_index_r <= 10'd0;
      span_open_r    <= 1'b0;
      gap_seen_r     <= 1'b0;
      open_bottom_r  <= 10'd0;
      open_length_r  <= 11'd0;
    end else if (in_acc) begin
      height_index_r <= height_index_nxt;
      if (top) begin
        span_open_r   <= 1'b0;
        gap_seen_r    <= 1'b0;
        open_bottom_r <= 10'd0;
        open_length_r <= 11'd0;
      end else begin
        span_open_r   <= span_open_nxt;
        gap_seen_r    <= gap_seen_nxt;
        open_bottom_r <= open_bottom_nxt;
        open_length_r <= open_length_nxt;
      end
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (in_acc && (n_res != 2'd0)) begin
      mem_r[wr_ptr_r] <= first_rec;
    end
    if (in_acc && (n_res == 2'd2)) begin
      mem_r[wr_ptr_r + 2'd1] <= top_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      if (in_acc) begin
        wr_ptr_r <= wr_ptr_r + n_res;
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      cnt_r <= cnt_r + (in_acc ? {1'b0, n_res} : 3'd0) - {2'b00, out_acc};
    end
  end

  assign out_tdata = {3'b000, mem_r[rd_ptr_r].span_height, mem_r[rd_ptr_r].span_bottom};
  assign out_tuser = mem_r[rd_ptr_r].span_valid;
  assign out_tlast = mem_r[rd_ptr_r].column_end;

endmodule
